// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file itaf_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define ITAF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itaf assertion failed");

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define ITAF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itaf assertion failed");

`endif

// ----- hdl/itaf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itaf_pkg
// Types, constants and the digit table of the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package itaf_pkg;

  // Reciprocal of ten: floor(x / 10) == (x * RECIP_DIV10) >> DIV10_SHIFT
  // for every 32-bit x.
  localparam logic [31:0] RECIP_DIV10 = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  localparam int MAX_DIGITS  = 10;
  localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_X     = 8'h78;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_PLAN,
    ST_PFX_ZERO,
    ST_PFX_X,
    ST_SIGN_LEAD,
    ST_PAD,
    ST_SIGN_TRAIL,
    ST_DIGITS
  } state_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    unique case (d)
      4'h0: c = 8'h30;
      4'h1: c = 8'h31;
      4'h2: c = 8'h32;
      4'h3: c = 8'h33;
      4'h4: c = 8'h34;
      4'h5: c = 8'h35;
      4'h6: c = 8'h36;
      4'h7: c = 8'h37;
      4'h8: c = 8'h38;
      4'h9: c = 8'h39;
      4'hA: c = 8'h41;
      4'hB: c = 8'h42;
      4'hC: c = 8'h43;
      4'hD: c = 8'h44;
      4'hE: c = 8'h45;
      4'hF: c = 8'h46;
      default: c = 8'h30;
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/itaf_digit_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itaf_digit_unit
// Shared divide-by-radix unit: splits off the lowest digit of a magnitude.
// Decimal results follow the registered reciprocal product; hex is direct.
// ----------------------------------------------------------------------------
module itaf_digit_unit (
  input  logic        clk,
  input  logic [31:0] mag,
  input  logic        base_hex,
  output logic [31:0] quot,
  output logic [3:0]  rem
);

  logic [63:0] prod_r;
  logic [31:0] q_dec;
  logic [31:0] q_dec_x10;
  logic [31:0] r_dec;

  always_ff @(posedge clk) begin
    prod_r <= 64'(mag) * 64'(itaf_pkg::RECIP_DIV10);
  end

  assign q_dec     = 32'(prod_r[63:itaf_pkg::DIV10_SHIFT]);
  assign q_dec_x10 = {q_dec[28:0], 3'b000} + {q_dec[30:0], 1'b0};
  assign r_dec     = mag - q_dec_x10;

  always_comb begin
    if (base_hex) begin
      quot = {4'h0, mag[31:4]};
      rem  = mag[3:0];
    end else begin
      quot = q_dec;
      rem  = r_dec[3:0];
    end
  end

endmodule

// ----- hdl/integer_to_ascii_formatter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Formats one 32-bit integer per input transfer as a run of ASCII characters.
// ----------------------------------------------------------------------------
// Channel  Direction  Ports                                          Handshake
// in       input      in_value in_base_hex in_signed_mode            in_valid/in_ready
//                     in_min_width in_zero_pad
// out      output     out_char_out out_last                          out_valid/out_ready
//
// Each digit passes through the shared divide unit in two states: ST_MUL
// (registered reciprocal product), then ST_DIV (quotient and remainder), for
// up to ten decimal digits. The planning state ST_PLAN follows, then one character
// per cycle goes into the output register while the output is not stalled, up to 33
// characters. Output stalls hold the sequencer; the next number is taken once the last
// character is in the output register. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_value,
  input  logic        in_base_hex,
  input  logic        in_signed_mode,
  input  logic [4:0]  in_min_width,
  input  logic        in_zero_pad,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char_out,
  output logic        out_last
);

  localparam int IW = itaf_pkg::DIGIT_IDX_W;

  itaf_pkg::state_t state_r, state_nxt, body_first;

  logic [31:0] mag_r;
  logic        hex_r;
  logic        neg_r;
  logic [4:0]  width_r;
  logic        zpad_r;
  logic [IW-1:0] nd_r;
  logic [4:0]  pad_r;
  logic [3:0]  digit_r [itaf_pkg::MAX_DIGITS];

  logic [31:0] quot;
  logic [3:0]  rem;
  logic [IW-1:0] nd_inc;
  logic [IW-1:0] rd_idx;
  logic [4:0]  used;
  logic [4:0]  pad_calc;
  logic        in_xfer;
  logic        out_free;

  logic        out_load;
  logic [7:0]  char_nxt;
  logic        last_nxt;
  logic        out_valid_r;
  logic [7:0]  out_char_r;
  logic        out_last_r;

  itaf_digit_unit u_digit (
    .clk      (clk),
    .mag      (mag_r),
    .base_hex (hex_r),
    .quot     (quot),
    .rem      (rem)
  );

  assign in_ready = (state_r == itaf_pkg::ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign nd_inc   = nd_r + IW'(1);
  assign rd_idx   = nd_r - IW'(1);
  assign used     = 5'(nd_inc) + 5'(neg_r);
  assign pad_calc = (width_r > used) ? (width_r - used) : 5'd0;

  // First state of the text after the optional prefix.
  always_comb begin
    if (zpad_r) begin
      if (neg_r)               body_first = itaf_pkg::ST_SIGN_LEAD;
      else if (pad_r != 5'd0)  body_first = itaf_pkg::ST_PAD;
      else                     body_first = itaf_pkg::ST_DIGITS;
    end else begin
      if (pad_r != 5'd0)       body_first = itaf_pkg::ST_PAD;
      else if (neg_r)          body_first = itaf_pkg::ST_SIGN_TRAIL;
      else                     body_first = itaf_pkg::ST_DIGITS;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      itaf_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = itaf_pkg::ST_MUL;
      end
      itaf_pkg::ST_MUL: begin
        state_nxt = itaf_pkg::ST_DIV;
      end
      itaf_pkg::ST_DIV: begin
        state_nxt = (quot == 32'd0) ? itaf_pkg::ST_PLAN : itaf_pkg::ST_MUL;
      end
      itaf_pkg::ST_PLAN: begin
        state_nxt = hex_r ? itaf_pkg::ST_PFX_ZERO : body_first;
      end
      itaf_pkg::ST_PFX_ZERO: begin
        if (out_free) state_nxt = itaf_pkg::ST_PFX_X;
      end
      itaf_pkg::ST_PFX_X: begin
        if (out_free) state_nxt = body_first;
      end
      itaf_pkg::ST_SIGN_LEAD: begin
        if (out_free) begin
          state_nxt = (pad_r != 5'd0) ? itaf_pkg::ST_PAD : itaf_pkg::ST_DIGITS;
        end
      end
      itaf_pkg::ST_PAD: begin
        if (out_free && pad_r == 5'd1) begin
          state_nxt = (!zpad_r && neg_r) ? itaf_pkg::ST_SIGN_TRAIL : itaf_pkg::ST_DIGITS;
        end
      end
      itaf_pkg::ST_SIGN_TRAIL: begin
        if (out_free) state_nxt = itaf_pkg::ST_DIGITS;
      end
      itaf_pkg::ST_DIGITS: begin
        if (out_free && nd_r == IW'(1)) state_nxt = itaf_pkg::ST_IDLE;
      end
      default: state_nxt = itaf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_load = 1'b0;
    char_nxt = itaf_pkg::CHAR_ZERO;
    last_nxt = 1'b0;
    unique case (state_r)
      itaf_pkg::ST_PFX_ZERO: begin
        out_load = out_free;
        char_nxt = itaf_pkg::CHAR_ZERO;
      end
      itaf_pkg::ST_PFX_X: begin
        out_load = out_free;
        char_nxt = itaf_pkg::CHAR_X;
      end
      itaf_pkg::ST_SIGN_LEAD, itaf_pkg::ST_SIGN_TRAIL: begin
        out_load = out_free;
        char_nxt = itaf_pkg::CHAR_MINUS;
      end
      itaf_pkg::ST_PAD: begin
        out_load = out_free;
        char_nxt = zpad_r ? itaf_pkg::CHAR_ZERO : itaf_pkg::CHAR_SPACE;
      end
      itaf_pkg::ST_DIGITS: begin
        out_load = out_free;
        char_nxt = itaf_pkg::digit_char(digit_r[rd_idx]);
        last_nxt = (nd_r == IW'(1));
      end
      itaf_pkg::ST_IDLE, itaf_pkg::ST_MUL, itaf_pkg::ST_DIV, itaf_pkg::ST_PLAN: begin
        out_load = 1'b0;
      end
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itaf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      neg_r   <= in_signed_mode && in_value[31];
      mag_r   <= (in_signed_mode && in_value[31]) ? (32'd0 - in_value) : in_value;
      hex_r   <= in_base_hex;
      width_r <= in_min_width;
      zpad_r  <= in_zero_pad;
      nd_r    <= '0;
    end else if (state_r == itaf_pkg::ST_DIV) begin
      digit_r[nd_r] <= rem;
      nd_r          <= nd_inc;
      mag_r         <= quot;
      if (quot == 32'd0) pad_r <= pad_calc;
    end else if (out_free && state_r == itaf_pkg::ST_PAD) begin
      pad_r <= pad_r - 5'd1;
    end else if (out_free && state_r == itaf_pkg::ST_DIGITS) begin
      nd_r <= rd_idx;
    end
    if (out_load) begin
      out_char_r <= char_nxt;
      out_last_r <= last_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;
  assign out_last     = out_last_r;

endmodule

// ----- hdl/itaf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itaf_checker
// Port-level checks of the formatter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itaf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char_out,
  input logic       out_last
);

  // A stalled character holds its value.
  `ITAF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char_out) && $stable(out_last))

  // The block is busy in the cycle after it takes a number.
  `ITAF_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)

  // While ready for a new number, any waiting character closes the previous run.
  `ITAF_ASSERT_SAME(a_idle_only_last, in_ready && out_valid, out_last)

  // A run always ends on a digit.
  `ITAF_ASSERT_SAME(a_last_is_digit, out_valid && out_last, (out_char_out >= 8'h30 && out_char_out <= 8'h39) || (out_char_out >= 8'h41 && out_char_out <= 8'h46))

endmodule

bind integer_to_ascii_formatter_core itaf_checker u_itaf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_char_out (out_char_out),
  .out_last     (out_last)
);
